>>> hdl/immersed_boundary_forcing_relax_defines.svh
// Assertion macros shared by the immersed boundary forcing block
`ifndef IMMERSED_BOUNDARY_FORCING_RELAX_DEFINES_SVH
`define IMMERSED_BOUNDARY_FORCING_RELAX_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ibfr_pkg.sv
// Package of types, constants and functions for the immersed boundary forcing block
package ibfr_pkg;

	localparam int VALUE_W = 32;
	localparam int DIST_FRAC_BITS = 16;
	localparam int DIST_W = DIST_FRAC_BITS + 1;
	localparam int DEN_W = DIST_FRAC_BITS + 2;
	localparam int COEF_W = DIST_W + 1;
	localparam int PROD_W = VALUE_W + DIST_W + 1;
	localparam int SAT_W = VALUE_W + 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEPS = VALUE_W / 2;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	localparam logic [DIST_W-1:0] FRAC_ONE = DIST_W'(1) << DIST_FRAC_BITS;

	localparam logic [1:0] REG_OMEGA = 2'd0;
	localparam logic [1:0] REG_BND_X = 2'd1;
	localparam logic [1:0] REG_BND_Y = 2'd2;
	localparam logic [1:0] REG_BND_Z = 2'd3;

	localparam logic [1:0] DIR_X = 2'd0;
	localparam logic [1:0] DIR_Y = 2'd1;
	localparam logic [1:0] DIR_Z = 2'd2;
	localparam logic [1:0] DIR_NONE = 2'd3;

	typedef struct packed {
		logic [DIST_W-1:0] w;
		logic signed [VALUE_W-1:0] bnd_x;
		logic signed [VALUE_W-1:0] bnd_y;
		logic signed [VALUE_W-1:0] bnd_z;
	} cfg_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] cell_val;
		logic signed [VALUE_W-1:0] nb;
		logic signed [VALUE_W-1:0] wall;
		logic [DIST_W-1:0] xic;
		logic first;
		logic upd;
		logic last;
	} cmd_t;

	function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-VALUE_W:0] top;
		logic signed [VALUE_W-1:0] r;
		top = v[SAT_W-1:VALUE_W-1];
		if ((&top) || !(|top))
			r = v[VALUE_W-1:0];
		else if (v[SAT_W-1])
			r = {1'b1, {(VALUE_W-1){1'b0}}};
		else
			r = {1'b0, {(VALUE_W-1){1'b1}}};
		return r;
	endfunction

endpackage

>>> hdl/ibfr_front.sv
// Front end: accepts face requests, tracks the largest distance and classifies each face
module ibfr_front import ibfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  cfg_t cfg,
	input  logic signed [VALUE_W-1:0] cell_value,
	input  logic [DIST_W-1:0] face_distance,
	input  logic signed [VALUE_W-1:0] neighbor_value,
	input  logic [1:0] direction,
	input  logic forced,
	input  logic first_face,
	input  logic last_face,
	output cmd_t cmd
);

	logic [DIST_W-1:0] largest_q;
	logic [DIST_W-1:0] dist_c;
	logic [DIST_W-1:0] base_c;
	logic upd_c;
	logic signed [VALUE_W-1:0] wall_c;

	always_comb begin
		dist_c = (face_distance > FRAC_ONE) ? FRAC_ONE : face_distance;
		base_c = first_face ? '0 : largest_q;
		upd_c = forced && (dist_c > base_c);
		case (direction)
			DIR_X: wall_c = cfg.bnd_x;
			DIR_Y: wall_c = cfg.bnd_y;
			DIR_Z: wall_c = cfg.bnd_z;
			default: wall_c = '0;
		endcase
		cmd.cell_val = cell_value;
		cmd.nb = neighbor_value;
		cmd.wall = wall_c;
		cmd.xic = FRAC_ONE - dist_c;
		cmd.first = first_face;
		cmd.upd = upd_c;
		cmd.last = last_face;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= '0;
		end else if (take) begin
			largest_q <= upd_c ? dist_c : base_c;
		end
	end

endmodule

>>> hdl/ibfr_queue.sv
// Short request queue between the front end and the back end
module ibfr_queue import ibfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic q_full,
	output logic q_empty
);

	cmd_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign q_full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/ibfr_back.sv
// Back end: interpolation target by iterative division, relaxation and result register
module ibfr_back import ibfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  cmd_t cmd,
	input  logic q_empty,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output logic signed [VALUE_W-1:0] new_value
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_SUM = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_FIX = 3'd4;
	localparam logic [2:0] ST_REL2 = 3'd5;
	localparam logic [2:0] ST_REL3 = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic signed [VALUE_W-1:0] run_q;
	logic signed [VALUE_W-1:0] tgt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] p1_q;
	logic neg_q;
	logic [DIST_W-1:0] rem_q;
	logic [VALUE_W-1:0] qd_q;
	logic [DCNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic signed [VALUE_W-1:0] out_q;

	logic signed [COEF_W-1:0] mul_a;
	logic signed [VALUE_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] wall_ext;
	logic signed [PROD_W-1:0] num_c;
	logic [PROD_W-1:0] mag_c;
	logic [DEN_W-1:0] dvs_c;
	logic [DEN_W-1:0] t1_c;
	logic [DEN_W-1:0] t2_c;
	logic ge1_c;
	logic ge2_c;
	logic [DIST_W-1:0] r1_c;
	logic [DIST_W-1:0] r2_c;
	logic signed [SAT_W-1:0] qv_c;
	logic signed [SAT_W-1:0] tv_c;
	logic signed [PROD_W-1:0] rsum_c;
	logic out_free;

	assign out_free = !out_valid_q || pop;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign empty = !out_valid_q;
	assign new_value = out_q;

	always_comb begin
		case (state_q)
			ST_MUL: begin
				mul_a = $signed({1'b0, cmd_q.xic});
				mul_b = cmd_q.nb;
			end
			ST_FIX: begin
				mul_a = $signed({1'b0, FRAC_ONE - cfg.w});
				mul_b = run_q;
			end
			default: begin
				mul_a = $signed({1'b0, cfg.w});
				mul_b = tgt_q;
			end
		endcase
		mul_p = mul_a * mul_b;

		wall_ext = PROD_W'(cmd_q.wall);
		num_c = (wall_ext <<< DIST_FRAC_BITS) + prod_q;
		mag_c = num_c[PROD_W-1] ? PROD_W'(-num_c) : PROD_W'(num_c);

		dvs_c = DEN_W'(FRAC_ONE) + DEN_W'(cmd_q.xic);
		t1_c = {rem_q, qd_q[VALUE_W-1]};
		ge1_c = (t1_c >= dvs_c);
		r1_c = ge1_c ? DIST_W'(t1_c - dvs_c) : DIST_W'(t1_c);
		t2_c = {r1_c, qd_q[VALUE_W-2]};
		ge2_c = (t2_c >= dvs_c);
		r2_c = ge2_c ? DIST_W'(t2_c - dvs_c) : DIST_W'(t2_c);

		qv_c = $signed({2'b00, qd_q});
		tv_c = neg_q ? (-qv_c - SAT_W'(rem_q != '0)) : qv_c;

		rsum_c = p1_q + prod_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
			end
			ST_MUL: begin
				prod_q <= mul_p;
			end
			ST_SUM: begin
				neg_q <= num_c[PROD_W-1];
				rem_q <= DIST_W'(mag_c[VALUE_W+DIST_FRAC_BITS-1:VALUE_W]);
				qd_q <= mag_c[VALUE_W-1:0];
			end
			ST_DIV: begin
				rem_q <= r2_c;
				qd_q <= {qd_q[VALUE_W-3:0], ge1_c, ge2_c};
			end
			ST_FIX: begin
				tgt_q <= sat_val(tv_c);
				p1_q <= mul_p;
			end
			ST_REL2: begin
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
		if (state_q == ST_EMIT && out_free) begin
			out_q <= run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (cmd.first) begin
							run_q <= cmd.cell_val;
						end
						if (cmd.upd) begin
							state_q <= ST_MUL;
						end else if (cmd.last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					state_q <= ST_REL2;
				end
				ST_REL2: begin
					state_q <= ST_REL3;
				end
				ST_REL3: begin
					run_q <= sat_val(rsum_c[DIST_FRAC_BITS+SAT_W-1:DIST_FRAC_BITS]);
					state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/immersed_boundary_forcing_relax.sv
// Top level of the immersed boundary forcing block: register port, front end, queue, back end
//
// Takes the faces of one wall-adjacent cell as consecutive requests (first_face opens a
// cell, last_face closes it and yields one new_value). The front end takes one request per
// cycle, while the queue is not full, into a two-entry queue while the back end works
// through it. A face that raises the largest wall distance of a forced cell uses one shared
// 18 by 32 bit multiplier three times and a divider that retires two quotient bits per
// cycle. Other faces leave the back end idle; a last face also has it load the result
// register. The result register lets the back end go on while a result waits to be popped.
// Registers sit at byte addresses 0 (omega), 4, 8 and 12 (wall values for x, y and z);
// write them only while the block is idle.
`include "immersed_boundary_forcing_relax_defines.svh"

module immersed_boundary_forcing_relax import ibfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic signed [VALUE_W-1:0] cell_value,
	input  logic [DIST_W-1:0] face_distance,
	input  logic signed [VALUE_W-1:0] neighbor_value,
	input  logic [1:0] direction,
	input  logic forced,
	input  logic first_face,
	input  logic last_face,
	output logic empty,
	input  logic pop,
	output logic signed [VALUE_W-1:0] new_value
);

	logic [DIST_W-1:0] omega_q;
	logic signed [VALUE_W-1:0] bnd_x_q;
	logic signed [VALUE_W-1:0] bnd_y_q;
	logic signed [VALUE_W-1:0] bnd_z_q;
	logic wr_en;
	logic [1:0] reg_idx;
	cfg_t cfg;
	cmd_t f_cmd;
	cmd_t b_cmd;
	logic take;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= FRAC_ONE;
			bnd_x_q <= '0;
			bnd_y_q <= '0;
			bnd_z_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OMEGA: omega_q <= pwdata[DIST_W-1:0];
				REG_BND_X: bnd_x_q <= pwdata[VALUE_W-1:0];
				REG_BND_Y: bnd_y_q <= pwdata[VALUE_W-1:0];
				REG_BND_Z: bnd_z_q <= pwdata[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OMEGA: prdata = DATA_W'(omega_q);
			REG_BND_X: prdata = bnd_x_q;
			REG_BND_Y: prdata = bnd_y_q;
			REG_BND_Z: prdata = bnd_z_q;
			default: prdata = '0;
		endcase
		cfg.w = (omega_q > FRAC_ONE) ? FRAC_ONE : omega_q;
		cfg.bnd_x = bnd_x_q;
		cfg.bnd_y = bnd_y_q;
		cfg.bnd_z = bnd_z_q;
	end

	assign full = q_full;
	assign take = push && !q_full;

	ibfr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.cfg            (cfg),
		.cell_value     (cell_value),
		.face_distance  (face_distance),
		.neighbor_value (neighbor_value),
		.direction      (direction),
		.forced         (forced),
		.first_face     (first_face),
		.last_face      (last_face),
		.cmd            (f_cmd)
	);

	ibfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wdata   (f_cmd),
		.rd      (q_pop),
		.rdata   (b_cmd),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	ibfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (b_cmd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.new_value (new_value)
	);

	`ASSERT_IMPLY(a_queue_full_not_empty, clk, arst_n, q_full, !q_empty)
	`ASSERT_IMPLY(a_pop_has_entry, clk, arst_n, q_pop, !q_empty)
	`ASSERT_NEXT(a_take_fills_queue, clk, arst_n, take, !q_empty || $past(q_pop))

endmodule
